// ----- sv/msd_pkg.sv -----
// Shared constants, types and helper functions for the Morse stream decoder.
// Depends on nothing; msd_walk and the top level refer to it by scoped names.
package msd_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int CHAR_W      = 8;

  // Longest code that a walk may follow before it is marked as overflowed.
  localparam logic [2:0] MAX_SYMBOLS   = 3'd5;
  // Longest code that a table write may carry.
  localparam logic [2:0] ENTRY_MAX_LEN = 3'd5;

  localparam logic [CHAR_W-1:0] CH_UNKNOWN = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  localparam logic KIND_STREAM = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  localparam logic [TABLE_AW-1:0] ROOT_NODE = TABLE_AW'(1);

  // Table access and result request produced by the walk unit for one beat.
  typedef struct packed {
    logic                rd_en;
    logic [TABLE_AW-1:0] rd_addr;
    logic                wr_en;
    logic [TABLE_AW-1:0] wr_addr;
    logic [CHAR_W-1:0]   wr_data;
    logic                res_valid;
    logic                res_from_table;
    logic [CHAR_W-1:0]   res_char;
  } msd_req_t;

  // Heap index of a code path: a leading one followed by the len low path bits.
  function automatic logic [TABLE_AW-1:0] entry_index(input logic [2:0] len,
                                                       input logic [4:0] path);
    logic [TABLE_AW-1:0] lead;
    logic [TABLE_AW-1:0] mask;
    lead = TABLE_AW'(1) << len;
    mask = lead - TABLE_AW'(1);
    return lead | (TABLE_AW'(path) & mask);
  endfunction

endpackage

// ----- sv/msd_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; the read data holds its value while no read is enabled.
module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/msd_walk.sv -----
// Walk state of the code tree and decode of one input beat into table and result requests.
// Depends on msd_pkg for character codes, limits and the request struct.
module msd_walk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic                  kind,
  input  logic [7:0]            ch,
  input  logic [7:0]            letter,
  input  logic [2:0]            len,
  input  logic [4:0]            path,
  output msd_pkg::msd_req_t     req
);

  logic [msd_pkg::TABLE_AW-1:0] node_index_r, node_index_nxt;
  logic                         walk_stopped_r, walk_stopped_nxt;
  logic                         walk_overflow_r, walk_overflow_nxt;
  logic [2:0]                   symbol_count_r, symbol_count_nxt;

  logic [msd_pkg::TABLE_AW:0]   next_node;
  logic                         is_symbol;
  logic                         too_deep;

  assign next_node = {node_index_r, (ch == msd_pkg::CH_DASH)};
  assign too_deep  = (symbol_count_r >= msd_pkg::MAX_SYMBOLS) ||
                     next_node[msd_pkg::TABLE_AW];

  always_comb begin
    node_index_nxt    = node_index_r;
    walk_stopped_nxt  = walk_stopped_r;
    walk_overflow_nxt = walk_overflow_r;
    symbol_count_nxt  = symbol_count_r;
    is_symbol         = 1'b0;

    req                = '0;
    req.rd_addr        = node_index_r;
    req.wr_addr        = msd_pkg::entry_index(len, path);
    req.wr_data        = letter;
    req.res_char       = msd_pkg::CH_UNKNOWN;

    if (kind == msd_pkg::KIND_WRITE) begin
      req.wr_en = (len <= msd_pkg::ENTRY_MAX_LEN);
    end else begin
      case (ch)
        msd_pkg::CH_DOT, msd_pkg::CH_DASH: begin
          is_symbol = 1'b1;
        end
        msd_pkg::CH_SPACE: begin
          // Emit the letter reached, then restart at the root.
          req.res_valid      = 1'b1;
          req.res_from_table = !walk_overflow_r;
          req.rd_en          = !walk_overflow_r;
          node_index_nxt     = msd_pkg::ROOT_NODE;
          walk_stopped_nxt   = 1'b0;
          walk_overflow_nxt  = 1'b0;
          symbol_count_nxt   = 3'd0;
        end
        msd_pkg::CH_SLASH: begin
          req.res_valid = 1'b1;
          req.res_char  = msd_pkg::CH_SPACE;
        end
        default: begin
          walk_stopped_nxt = 1'b1;
        end
      endcase
    end

    if (is_symbol && !walk_stopped_r && !walk_overflow_r) begin
      if (too_deep) begin
        walk_overflow_nxt = 1'b1;
      end else begin
        node_index_nxt   = next_node[msd_pkg::TABLE_AW-1:0];
        symbol_count_nxt = symbol_count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_index_r    <= msd_pkg::ROOT_NODE;
      walk_stopped_r  <= 1'b0;
      walk_overflow_r <= 1'b0;
      symbol_count_r  <= 3'd0;
    end else if (take) begin
      node_index_r    <= node_index_nxt;
      walk_stopped_r  <= walk_stopped_nxt;
      walk_overflow_r <= walk_overflow_nxt;
      symbol_count_r  <= symbol_count_nxt;
    end
  end

  // The leading one of the node index always sits at the depth that was walked.
  a_node_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (node_index_r >> symbol_count_r) == msd_pkg::TABLE_AW'(1))
    else $error("node index does not match the symbol count");

  // A walk never goes deeper than the symbol limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    take && is_symbol |=> symbol_count_r <= msd_pkg::MAX_SYMBOLS)
    else $error("symbol count passed the limit");

endmodule

// ----- sv/morse_stream_decoder.sv -----
// Top level of the Morse stream decoder: walk unit, letter table and result stages.
// Depends on msd_pkg, msd_ram and msd_walk.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_ready   in_kind, in_char, in_entry_letter,
//                                            in_entry_length, in_entry_path
//   result    out        out_valid/out_ready out_char
//
// One beat is accepted per cycle while in_ready is high. A space or slash passes
// through the table read stage, then the output register; other beats give none.
// Reset (rst_n, synchronous) returns the walk to the root and clears the valid
// bits of the table, so every entry reads as '?' until it is written.
// While a result waits at the output, one more result may sit in the read stage;
// input is held off only when both are full and out_ready is low.
module morse_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_char,
  input  logic [7:0] in_entry_letter,
  input  logic [2:0] in_entry_length,
  input  logic [4:0] in_entry_path,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char
);

  msd_pkg::msd_req_t req;

  logic accept;
  logic s1_free;
  logic s1_move;

  logic [msd_pkg::TABLE_DEPTH-1:0] entry_valid_r;
  logic [msd_pkg::CHAR_W-1:0]      ram_rdata;

  // Read stage: holds a pending result while the table read completes.
  logic                       s1_valid_r;
  logic                       s1_use_ram_r;
  logic [msd_pkg::CHAR_W-1:0] s1_char_r;

  logic                       out_valid_r;
  logic [msd_pkg::CHAR_W-1:0] out_char_r;

  // The read stage can take a beat when it is empty or drains into the output
  // register this cycle.
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_free  = !s1_valid_r || !out_valid_r || out_ready;
  assign in_ready = s1_free;
  assign accept   = in_valid && in_ready;

  msd_walk u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (accept),
    .kind   (in_kind),
    .ch     (in_char),
    .letter (in_entry_letter),
    .len    (in_entry_length),
    .path   (in_entry_path),
    .req    (req)
  );

  // The read is issued only on an accepted beat, so the read data holds while a
  // result is parked in the read stage.
  msd_ram #(
    .WIDTH (msd_pkg::CHAR_W),
    .DEPTH (msd_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (accept && req.wr_en),
    .waddr (req.wr_addr),
    .wdata (req.wr_data),
    .re    (accept && req.rd_en),
    .raddr (req.rd_addr),
    .rdata (ram_rdata)
  );

  // An entry that was never written reads as '?'.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (accept && req.wr_en) begin
      entry_valid_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept && req.res_valid) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.res_valid) begin
      s1_use_ram_r <= req.res_from_table && entry_valid_r[req.rd_addr];
      s1_char_r    <= req.res_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_char_r <= s1_use_ram_r ? ram_rdata : s1_char_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;

  // Every accepted space or slash lands in the read stage.
  a_result_staged: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req.res_valid |=> s1_valid_r)
    else $error("accepted result beat did not reach the read stage");

  // Table read data holds while a result that needs it is parked.
  a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_use_ram_r && !s1_move |=> $stable(ram_rdata))
    else $error("table read data changed under a parked result");

  // A table write never coincides with a table read.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !(req.wr_en && req.rd_en))
    else $error("table read and write requested in one beat");

endmodule
